>>> rtl/irn_pkg.sv
// Shared types, register indexes and digit tables for the Roman numeral converter.
package irn_pkg;

    localparam int unsigned LIMIT_W = 12;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd1;

    localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RESET = 12'd0;
    localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RESET = 12'd3000;

    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture input value
        logic check;   // run range check, start conversion or post invalid beat
        logic step;    // one greedy step
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register can take a beat this cycle
        logic pass;        // captured value is inside the limits
        logic final_char;  // this step posts the last character
    } status_t;

    function automatic logic [LIMIT_W-1:0] digit_value(input logic [IDX_W-1:0] idx);
        logic [LIMIT_W-1:0] v;
        case (idx)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_first(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd0:    c = "M";
            4'd1:    c = "C";
            4'd2:    c = "D";
            4'd3:    c = "C";
            4'd4:    c = "C";
            4'd5:    c = "X";
            4'd6:    c = "L";
            4'd7:    c = "X";
            4'd8:    c = "X";
            4'd9:    c = "I";
            4'd10:   c = "V";
            4'd11:   c = "I";
            default: c = "I";
        endcase
        return c;
    endfunction

    // second letter of subtractive pairs, CHAR_NONE for single letters
    function automatic logic [CHAR_W-1:0] digit_second(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd1:    c = "M";
            4'd3:    c = "D";
            4'd5:    c = "C";
            4'd7:    c = "L";
            4'd9:    c = "X";
            4'd11:   c = "V";
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/irn_ctrl.sv
// Controller state machine: accept, range check, greedy emit sequencing.
module irn_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  irn_pkg::status_t status,
    output irn_pkg::cmd_t    cmd
);
    import irn_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.out_free)
                begin
                    state_next = status.pass ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && status.final_char)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        cmd.load  = 1'b0;
        cmd.check = 1'b0;
        cmd.step  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.check = status.out_free;
            end
            ST_EMIT:
            begin
                cmd.step = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/irn_datapath.sv
// Datapath: limit registers, remainder and digit index, output beat register.
module irn_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [irn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irn_pkg::LIMIT_W-1:0]        cfg_data,
    input  logic signed [irn_pkg::VALUE_W-1:0] value,
    input  irn_pkg::cmd_t                      cmd,
    output irn_pkg::status_t                   status,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [irn_pkg::CHAR_W-1:0]         char_code,
    output logic                               last,
    output logic                               invalid
);
    import irn_pkg::*;

    logic [LIMIT_W-1:0]        lower_reg;
    logic [LIMIT_W-1:0]        upper_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [LIMIT_W-1:0]        rest_reg;
    logic [LIMIT_W-1:0]        rest_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic                      pend_reg;
    logic                      pend_next;

    logic                      out_valid_reg;
    logic [CHAR_W-1:0]         char_reg;
    logic                      last_reg;
    logic                      invalid_reg;

    logic [LIMIT_W-1:0]        dval;
    logic [CHAR_W-1:0]         dfirst;
    logic [CHAR_W-1:0]         dsecond;
    logic                      ge;
    logic [LIMIT_W-1:0]        diff;
    logic                      pass;
    logic                      emit_en;
    logic [CHAR_W-1:0]         emit_char;
    logic                      emit_last;
    logic                      out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= LOWER_LIMIT_RESET;
            upper_reg <= UPPER_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LOWER_LIMIT: lower_reg <= cfg_data;
                REG_UPPER_LIMIT: upper_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // limits are non-negative, so zero-extend and compare signed
    assign pass = (value_reg > $signed({{(VALUE_W-LIMIT_W){1'b0}}, lower_reg})) &&
                  (value_reg <= $signed({{(VALUE_W-LIMIT_W){1'b0}}, upper_reg}));

    assign dval    = digit_value(idx_reg);
    assign dfirst  = digit_first(idx_reg);
    assign dsecond = digit_second(idx_reg);
    assign ge      = rest_reg >= dval;
    assign diff    = rest_reg - dval;

    always_comb
    begin
        emit_en   = 1'b0;
        emit_char = dfirst;
        emit_last = 1'b0;
        rest_next = rest_reg;
        idx_next  = idx_reg;
        pend_next = pend_reg;
        if (pend_reg)
        begin
            emit_en   = 1'b1;
            emit_char = dsecond;
            emit_last = (rest_reg == '0);
            pend_next = 1'b0;
        end
        else if (ge)
        begin
            emit_en   = 1'b1;
            rest_next = diff;
            pend_next = (dsecond != CHAR_NONE);
            emit_last = (dsecond == CHAR_NONE) && (diff == '0);
        end
        else
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign status.out_free   = out_free;
    assign status.pass       = pass;
    assign status.final_char = emit_en && emit_last;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
        end
        if (cmd.check)
        begin
            rest_reg <= value_reg[LIMIT_W-1:0];
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            rest_reg <= rest_next;
            idx_reg  <= idx_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= (cmd.check && !pass) || (cmd.step && emit_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check && !pass)
        begin
            char_reg    <= CHAR_NONE;
            last_reg    <= 1'b1;
            invalid_reg <= 1'b1;
        end
        else if (cmd.step && emit_en)
        begin
            char_reg    <= emit_char;
            last_reg    <= emit_last;
            invalid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;
    assign invalid   = invalid_reg;

endmodule

>>> rtl/integer_to_roman_numeral.sv
// Top level of the integer to Roman numeral converter.
//
// Takes one signed 16-bit value per input beat and, when
// lower_limit < value <= upper_limit, sends its Roman numeral as ASCII
// characters, one output beat each, with last set on the final character.
// A value outside the limits gives one beat with char_code 0, last 1 and
// invalid 1. Digits are chosen greedily from 1000 down to 1; subtractive
// pairs (CM, CD, XC, XL, IX, IV) go out as two beats. One item is in work
// at a time: it is accepted, range checked, then walked through the
// thirteen-entry table with one step per character and one step for each
// digit value skipped; an output stall holds the walk. The greedy step is
// one compare and subtract on the 12-bit remainder. The next item is
// accepted while the final character still waits in the output register.
// Configuration: index 0 is lower_limit (reset 0), index 1 is upper_limit
// (reset 3000), 12 bits each; cfg_ready is always high, other indexes are
// ignored. Write only while idle.
module integer_to_roman_numeral
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [irn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irn_pkg::LIMIT_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [irn_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [irn_pkg::CHAR_W-1:0]         char_code,
    output logic                               last,
    output logic                               invalid
);
    import irn_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing: idle / check / emit
    irn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // limits, remainder walk and the output beat register
    irn_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last),
        .invalid   (invalid)
    );

endmodule

>>> tb/sv/roman_numeral_checker.sv
// Checker for the Roman numeral converter: predicts each beat and compares.
`timescale 1ns / 100ps

module roman_numeral_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [irn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [irn_pkg::LIMIT_W-1:0]         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [irn_pkg::VALUE_W-1:0]  value,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [irn_pkg::CHAR_W-1:0]          char_code,
    input  logic                                last,
    input  logic                                invalid,
    output int                                  fail_count,
    output int                                  pending
);
    import irn_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              inv;
    } roman_beat_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] weight;
        logic [CHAR_W-1:0]  head;
        logic [CHAR_W-1:0]  tail;
    } roman_sym_t;

    localparam int MAX_CHARS = 15;

    logic [LIMIT_W-1:0] lower_lim;
    logic [LIMIT_W-1:0] upper_lim;
    roman_beat_t        expected_beats[$];
    int                 mismatches = 0;

    assign fail_count = mismatches;

    function automatic roman_sym_t roman_symbol(input int k);
        case (k)
            0:       return {12'd1000, "M", CHAR_NONE};
            1:       return {12'd900,  "C", "M"};
            2:       return {12'd500,  "D", CHAR_NONE};
            3:       return {12'd400,  "C", "D"};
            4:       return {12'd100,  "C", CHAR_NONE};
            5:       return {12'd90,   "X", "C"};
            6:       return {12'd50,   "L", CHAR_NONE};
            7:       return {12'd40,   "X", "L"};
            8:       return {12'd10,   "X", CHAR_NONE};
            9:       return {12'd9,    "I", "X"};
            10:      return {12'd5,    "V", CHAR_NONE};
            11:      return {12'd4,    "I", "V"};
            default: return {12'd1,    "I", CHAR_NONE};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // greedy spelling of one value, or the single invalid beat
    task automatic predict_numeral(input logic signed [VALUE_W-1:0] v);
        int                num;
        int                rest;
        int                k;
        int                n;
        roman_sym_t        sym;
        logic [CHAR_W-1:0] spelled [0:MAX_CHARS];
        num = int'(v);
        if (!(num > int'(lower_lim) && num <= int'(upper_lim))) begin
            expected_beats.push_back({CHAR_NONE, 1'b1, 1'b1});
        end
        else begin
            rest = num;
            k = 0;
            n = 0;
            while (rest != 0 && k < 13 && n < MAX_CHARS) begin
                sym = roman_symbol(k);
                if (rest >= int'(sym.weight)) begin
                    rest -= int'(sym.weight);
                    spelled[n] = sym.head;
                    n++;
                    if (sym.tail != CHAR_NONE && n < MAX_CHARS) begin
                        spelled[n] = sym.tail;
                        n++;
                    end
                end
                else begin
                    k++;
                end
            end
            for (int i = 0; i < n; i++) begin
                expected_beats.push_back({spelled[i], (i == n - 1), 1'b0});
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lower_lim <= LOWER_LIMIT_RESET;
            upper_lim <= UPPER_LIMIT_RESET;
            expected_beats.delete();
            pending <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat, char_code", int'(char_code), 0);
                end
                else begin
                    roman_beat_t want;
                    want = expected_beats.pop_front();
                    if (char_code !== want.code)
                        report_mismatch("char_code", int'(char_code), int'(want.code));
                    if (last !== want.last)
                        report_mismatch("last", int'(last), int'(want.last));
                    if (invalid !== want.inv)
                        report_mismatch("invalid", int'(invalid), int'(want.inv));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LOWER_LIMIT: lower_lim <= cfg_data;
                    REG_UPPER_LIMIT: upper_lim <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_numeral(value);
            pending <= expected_beats.size();
        end
    end

endmodule

>>> tb/sv/tb_integer_to_roman_numeral.sv
// Top of the testbench: clock, reset, stimulus, receiver, watchdog and verdict.
`timescale 1ns / 100ps

module tb_integer_to_roman_numeral;
    import irn_pkg::*;

    // indexes that map to no register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // longest receiver hold-off, used once to back the block up
    localparam int HOLD_CYCLES = 300;
    // cycles with no beat on any channel before the run is called hung;
    // the slowest legal quiet stretch is the hold-off above
    localparam int IDLE_LIMIT  = 2000;
    // settle time after the last beat
    localparam int TAIL_CYCLES = 40;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [LIMIT_W-1:0]         cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [VALUE_W-1:0]  value;
    logic                       out_valid;
    logic                       out_stall;
    logic [CHAR_W-1:0]          char_code;
    logic                       last;
    logic                       invalid;

    int fail_count;
    int pending;

    // shared between stimulus and receiver
    bit no_idle  = 1'b0;   // both sides run without gaps
    bit hold_req = 1'b0;   // receiver should do its long hold-off next

    // limits currently loaded, so stimulus can aim inside and at the edges
    int cur_lower;
    int cur_upper;

    integer_to_roman_numeral uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last),
        .invalid   (invalid)
    );

    roman_numeral_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .last       (last),
        .invalid    (invalid),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns clock
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_idle();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly values that convert, some right at the limits, the rest
    // full-width noise so every bit of the field toggles.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (cur_lower < cur_upper && r < 60)
            return VALUE_W'($urandom_range(cur_lower + 1, cur_upper));
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0:       return VALUE_W'(cur_lower);
                1:       return VALUE_W'(cur_lower + 1);
                2:       return VALUE_W'(cur_upper);
                default: return VALUE_W'(cur_upper + 1);
            endcase
        end
        return VALUE_W'($urandom());
    endfunction

    // Leaves cfg_valid high so writes can go back to back; caller lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Offers one value after a random gap and holds it until accepted.
    // in_valid stays high on return so the next beat can follow at once.
    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (in_stall);
    endtask

    // Wait until every predicted beat has come out. pending is a register
    // the checker updates on the clock edge, so it is read after an edge.
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One random phase: load limits while idle, then a burst of values.
    task automatic run_phase(input int lo, input int hi, input int count,
                             input bit quiet, input bit press);
        drain();
        write_reg(REG_LOWER_LIMIT, lo[LIMIT_W-1:0]);
        write_reg(REG_UPPER_LIMIT, hi[LIMIT_W-1:0]);
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                      LIMIT_W'($urandom()));
        cfg_valid <= 1'b0;
        cur_lower = lo;
        cur_upper = hi;
        no_idle   = quiet;
        hold_req  = press;
        repeat (count)
            send_value(pick_value());
        in_valid <= 1'b0;
    endtask

    // Receiver: alternating stall and take stretches. On request it holds
    // off for a long stretch while the sender keeps offering beats.
    initial begin
        int busy;
        int run;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                busy = HOLD_CYCLES;
            end
            else begin
                busy = pick_idle();
            end
            if (busy > 0) begin
                out_stall <= 1'b1;
                repeat (busy) @(posedge clk);
            end
            out_stall <= 1'b0;
            run = no_idle ? 16 : $urandom_range(1, 6);
            repeat (run) @(posedge clk);
        end
    end

    // Watchdog: too long with no beat on any channel means the block hung.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL integer_to_roman_numeral");
        $finish;
    end

    // Main stimulus
    initial begin
        int lo;
        int hi;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_LOWER_LIMIT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        value     <= '0;
        cur_lower = int'(LOWER_LIMIT_RESET);
        cur_upper = int'(UPPER_LIMIT_RESET);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed, reset limits (0, 3000): zero and negatives always fail,
        // field extremes, each table entry, the upper edge and its neighbor.
        send_value(16'sd0);
        send_value(16'sd1);
        send_value(-16'sd1);
        send_value(16'sh8000);
        send_value(16'sd32767);
        send_value(16'sd3000);
        send_value(16'sd3001);
        send_value(16'sd4);
        send_value(16'sd9);
        send_value(16'sd40);
        send_value(16'sd90);
        send_value(16'sd400);
        send_value(16'sd900);
        send_value(16'sd1000);
        send_value(16'sd2888);
        send_value(16'sd1994);
        send_value(16'sd14);
        send_value(16'sd49);
        send_value(16'sd444);
        in_valid <= 1'b0;

        // Directed, limits opened to the full 12 bits: more than three M's,
        // the longest numeral, and dropped writes to the unused indexes.
        drain();
        write_reg(REG_LOWER_LIMIT, 12'd0);
        write_reg(REG_UPPER_LIMIT, 12'd4095);
        write_reg(REG_SPARE_A, 12'd7);
        write_reg(REG_SPARE_B, 12'd4095);
        cfg_valid <= 1'b0;
        cur_lower = 0;
        cur_upper = 4095;
        send_value(16'sd4095);
        send_value(16'sd4096);
        send_value(16'sd3888);
        send_value(16'sd3999);
        send_value(16'sd4000);
        send_value(16'sd3);
        in_valid <= 1'b0;

        // Random phases across several limit settings, extremes included.
        run_phase(0, 3000, 14, 1'b0, 1'b0);
        run_phase(0, 4095, 14, 1'b0, 1'b0);
        run_phase(4095, 4095, 8, 1'b0, 1'b0);   // nothing can pass
        run_phase(2500, 1200, 8, 1'b0, 1'b0);   // lower above upper
        run_phase(0, 1, 8, 1'b0, 1'b0);
        run_phase(3998, 3999, 8, 1'b0, 1'b0);
        lo = $urandom_range(0, 3000);
        hi = $urandom_range(lo + 1, 4095);
        run_phase(lo, hi, 14, 1'b1, 1'b1);      // long hold-off, block backs up
        lo = $urandom_range(0, 4095);
        hi = $urandom_range(0, 4095);
        run_phase(lo, hi, 14, 1'b1, 1'b0);      // no gaps on either side
        run_phase(1000, 3999, 14, 1'b0, 1'b0);

        // wait out every expected beat, then let the block settle
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS integer_to_roman_numeral");
        else
            $display("FAIL integer_to_roman_numeral");
        $finish;
    end

endmodule
